### design/dri_pkg.sv
// Package for the decimating ring buffer with linear interpolation readout.
// Holds sizes, register codes and shared types; depends on nothing.
package dri_pkg;

	localparam int BUFFER_DEPTH  = 16384;
	localparam int SAMPLE_BITS   = 24;
	localparam int FRACTION_BITS = 16;

	localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
	localparam int PHASE_W   = ADDR_W + FRACTION_BITS;
	localparam int GROUP_W   = 7;
	localparam int DECIM_W   = 3;
	localparam int STEP_W    = 20;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;

	// register map, index = paddr / 4
	localparam logic [REG_IDX_W-1:0] REG_DECIM = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_STEP  = 1'b1;

	localparam logic [DECIM_W-1:0] DECIM_RESET = 3'd2;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd16384;

	typedef logic [SAMPLE_BITS-1:0]   sample_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [FRACTION_BITS-1:0] frac_t;

	// side info that travels with the ring read data
	typedef struct packed {
		logic    hit0;   // lower neighbor written by this same transaction
		logic    hit1;   // upper neighbor written by this same transaction
		logic    vld0;   // lower neighbor written at some earlier time
		logic    vld1;   // upper neighbor written at some earlier time
		sample_t wdata;  // sample written by this transaction
		frac_t   frac;   // interpolation fraction
	} rd_side_t;

endpackage

### design/decimate_ring_interpolate.sv
// Decimating ring buffer read back at a fractional phase with linear interpolation.
// Takes one sample per cycle while the output is not stalled and gives one result
// per sample. The rate is set by the ring memory, which serves the write of the
// kept sample and both neighbor reads in the same cycle, and by the four-stage
// read/multiply pipeline behind it. A stalled output holds the whole pipeline.
// The ring reads as zero until written; a fill mark stands in for clearing, so
// there is no clearing pass after reset. Uses dri_pkg, dri_ring_mem and
// dri_interp.
module decimate_ring_interpolate (
	input  logic clk,
	input  logic arst_n,

	input  logic in_valid,
	output logic in_ready,
	input  logic signed [dri_pkg::SAMPLE_BITS-1:0] sample_in,

	output logic out_valid,
	input  logic out_ready,
	output logic signed [dri_pkg::SAMPLE_BITS-1:0] sample_out,

	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dri_pkg::PADDR_W-1:0] paddr,
	input  logic [dri_pkg::PDATA_W-1:0] pwdata,
	output logic [dri_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import dri_pkg::*;

	logic [DECIM_W-1:0] decim_q;
	logic [STEP_W-1:0]  step_q;
	logic [GROUP_W-1:0] group_q;
	logic [PHASE_W-1:0] phase_q;
	addr_t              windex_q;
	logic               filled_q;
	logic               v1_q, v2_q, v3_q, vout_q;

	logic en, accept, keep, we, cfg_wr;
	logic [GROUP_W-1:0] sel;
	logic [REG_IDX_W-1:0] reg_idx;
	addr_t i0, i1;
	rd_side_t side_d, side_s1;
	sample_t rdata0_s1, rdata1_s1;

	// pipeline advances unless the output transaction is stalled
	assign en        = !vout_q || out_ready;
	assign in_ready  = en;
	assign accept    = in_valid && en;
	assign out_valid = vout_q;

	// keep the last sample of each group
	assign sel  = GROUP_W'((8'd1 << decim_q) - 8'd1);
	assign keep = (group_q & sel) == sel;
	assign we   = accept && keep;

	// neighbor addresses and read side info
	assign i0 = phase_q[PHASE_W-1:FRACTION_BITS];
	assign i1 = i0 + addr_t'(1);

	always_comb begin
		side_d.hit0  = keep && (windex_q == i0);
		side_d.hit1  = keep && (windex_q == i1);
		side_d.vld0  = filled_q || (i0 < windex_q);
		side_d.vld1  = filled_q || (i1 < windex_q);
		side_d.wdata = sample_t'(sample_in);
		side_d.frac  = phase_q[FRACTION_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q  <= '0;
			phase_q  <= '0;
			windex_q <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			group_q <= group_q + GROUP_W'(1);
			phase_q <= phase_q + PHASE_W'(step_q);
			if (keep) begin
				windex_q <= windex_q + addr_t'(1);
				if (windex_q == addr_t'(BUFFER_DEPTH - 1)) begin
					filled_q <= 1'b1;
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			v3_q   <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v1_q   <= in_valid;
			v2_q   <= v1_q;
			v3_q   <= v2_q;
			vout_q <= v3_q;
		end
	end

	dri_ring_mem u_mem (
		.clk       (clk),
		.en        (en),
		.we        (we),
		.waddr     (windex_q),
		.wdata     (sample_t'(sample_in)),
		.raddr0    (i0),
		.raddr1    (i1),
		.rdata0_s1 (rdata0_s1),
		.rdata1_s1 (rdata1_s1)
	);

	dri_interp u_interp (
		.clk        (clk),
		.en         (en),
		.side_s1    (side_s1),
		.rdata0_s1  (rdata0_s1),
		.rdata1_s1  (rdata1_s1),
		.sample_out (sample_out)
	);

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_RESET;
			step_q  <= STEP_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DECIM: decim_q <= pwdata[DECIM_W-1:0];
				REG_STEP:  step_q  <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DECIM: prdata = PDATA_W'(decim_q);
			REG_STEP:  prdata = PDATA_W'(step_q);
			default:   prdata = '0;
		endcase
	end

	// write pointer moves only with an input transaction
	a_windex_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) |=> $stable(windex_q))
		else $error("write index moved without input transaction");

	// read phase moves only with an input transaction
	a_phase_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) |=> $stable(phase_q))
		else $error("read phase moved without input transaction");

	// once the ring has wrapped it stays fully written
	a_filled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |=> filled_q)
		else $error("fill mark cleared");

	// fill mark sets only as the write pointer wraps
	a_filled_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(filled_q) |-> (windex_q == '0))
		else $error("fill mark set without pointer wrap");

endmodule

### design/dri_ring_mem.sv
// Ring storage: one write port, two registered read ports.
// Uses dri_pkg for depth and sample width.
module dri_ring_mem (
	input  logic            clk,
	input  logic            en,
	input  logic            we,
	input  dri_pkg::addr_t  waddr,
	input  dri_pkg::sample_t wdata,
	input  dri_pkg::addr_t  raddr0,
	input  dri_pkg::addr_t  raddr1,
	output dri_pkg::sample_t rdata0_s1,
	output dri_pkg::sample_t rdata1_s1
);
	import dri_pkg::*;

	sample_t mem_q [BUFFER_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports, old data on a same-address write
	always_ff @(posedge clk) begin
		if (en) begin
			rdata0_s1 <= mem_q[raddr0];
			rdata1_s1 <= mem_q[raddr1];
		end
	end

endmodule

### design/dri_interp.sv
// Interpolation datapath: neighbor select, difference, multiply, round.
// Uses dri_pkg for widths and the read side-info struct.
module dri_interp (
	input  logic              clk,
	input  logic              en,
	input  dri_pkg::rd_side_t side_s1,
	input  dri_pkg::sample_t  rdata0_s1,
	input  dri_pkg::sample_t  rdata1_s1,
	output logic signed [dri_pkg::SAMPLE_BITS-1:0] sample_out
);
	import dri_pkg::*;

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
	localparam int ACC_W  = PROD_W;
	localparam sample_t SIGN_BIT = sample_t'(1) << (SAMPLE_BITS - 1);
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRACTION_BITS - 1);

	sample_t a_sel, b_sel, a_off, b_off;
	sample_t a_s2, a_s3;
	logic signed [DIFF_W-1:0] d_s2;
	frac_t f_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic [ACC_W-1:0] acc;

	// pick forwarded, stored or never-written (zero) value; go offset binary
	always_comb begin
		a_sel = side_s1.hit0 ? side_s1.wdata : (side_s1.vld0 ? rdata0_s1 : '0);
		b_sel = side_s1.hit1 ? side_s1.wdata : (side_s1.vld1 ? rdata1_s1 : '0);
		a_off = a_sel ^ SIGN_BIT;
		b_off = b_sel ^ SIGN_BIT;
	end

	// stage 2: base and difference
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_off;
			d_s2 <= signed'({1'b0, b_off}) - signed'({1'b0, a_off});
			f_s2 <= side_s1.frac;
		end
	end

	// stage 3: (b - a) * f
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_s2;
			prod_s3 <= d_s2 * signed'({1'b0, f_s2});
		end
	end

	// a * 2^F + (b - a) * f, round half up, back to two's complement
	assign acc = ACC_W'({a_s3, {FRACTION_BITS{1'b0}}}) + ACC_W'(prod_s3) + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			sample_out <= signed'(acc[FRACTION_BITS +: SAMPLE_BITS] ^ SIGN_BIT);
		end
	end

endmodule
